[sv/fira_pkg.sv]
// Shared constants, codes and types for the FIR filter with addend.
package fira_pkg;

  localparam int NTAPS     = 16;
  localparam int DLY_DEPTH = NTAPS + 1;
  localparam int IDX_W     = $clog2(DLY_DEPTH);
  localparam int FILL_W    = $clog2(DLY_DEPTH + 1);
  localparam int CI_W      = (NTAPS > 1) ? $clog2(NTAPS) : 1;

  localparam int SMP_W     = 16;
  localparam int TAP_W     = 5;
  localparam int CIDX_W    = 4;
  localparam int PROD_W    = 2 * SMP_W;
  localparam int ACC_W     = PROD_W + 1 + $clog2(NTAPS + 1);
  localparam int FILT_W    = 23;
  localparam int SUM_W     = (ACC_W - 14 > FILT_W + 1) ? ACC_W - 14 : FILT_W + 1;
  localparam int FILT_MAX  = 4194303;
  localparam int FILT_MIN  = -4194304;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAP_COUNT    = 2'd0,
    REG_USE_ADDEND   = 2'd1,
    REG_EMIT_DELAYED = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_LOAD   = 1'b1
  } kind_t;

  typedef struct packed {
    logic vld;
    logic first;
    logic prod;
    logic last;
  } mac_tag_t;

  typedef struct packed {
    logic                    done;
    logic signed [ACC_W-1:0] acc;
    logic signed [SMP_W-1:0] delayed;
  } mac_res_t;

endpackage

[sv/fira_dly_mem.sv]
// Circular sample memory holding the delay line, addressed by sample age.
module fira_dly_mem (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic signed [fira_pkg::SMP_W-1:0]   wr_data,
  input  logic                                rd_en,
  input  logic        [fira_pkg::IDX_W-1:0]   rd_age,
  output logic signed [fira_pkg::SMP_W-1:0]   rd_data
);

  localparam int DEPTH = fira_pkg::DLY_DEPTH;
  localparam int AW    = fira_pkg::IDX_W;

  logic signed [fira_pkg::SMP_W-1:0] mem [DEPTH];
  logic [AW-1:0]                     wp;
  logic [AW-1:0]                     wp_next;
  logic [fira_pkg::FILL_W-1:0]       fill;
  logic [AW-1:0]                     rd_addr;
  logic [AW:0]                       wrap_addr;
  logic signed [fira_pkg::SMP_W-1:0] rd_q;
  logic                              rd_ok;

  assign wp_next   = (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
  assign wrap_addr = {1'b0, wp} + (AW + 1)'(DEPTH) - {1'b0, rd_age};
  assign rd_addr   = (wp >= rd_age) ? wp - rd_age : wrap_addr[AW-1:0];
  assign rd_data   = rd_ok ? rd_q : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_next] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      fill  <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (wr_en) begin
        wp <= wp_next;
        if (fill != fira_pkg::FILL_W'(DEPTH)) begin
          fill <= fill + 1'b1;
        end
      end
      if (rd_en) begin
        rd_ok <= fira_pkg::FILL_W'(rd_age) < fill;
      end
    end
  end

endmodule

[sv/fira_coef_mem.sv]
// Coefficient memory with one valid bit per entry so unwritten entries read as zero.
module fira_coef_mem (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic        [fira_pkg::CI_W-1:0]    wr_idx,
  input  logic signed [fira_pkg::SMP_W-1:0]   wr_data,
  input  logic                                rd_en,
  input  logic        [fira_pkg::CI_W-1:0]    rd_idx,
  output logic signed [fira_pkg::SMP_W-1:0]   rd_data
);

  logic signed [fira_pkg::SMP_W-1:0] mem [fira_pkg::NTAPS];
  logic [fira_pkg::NTAPS-1:0]        written;
  logic signed [fira_pkg::SMP_W-1:0] rd_q;
  logic                              rd_ok;

  assign rd_data = rd_ok ? rd_q : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_ok   <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok <= written[rd_idx];
      end
    end
  end

endmodule

[sv/fira_mac.sv]
// Shared multiply-accumulate pipeline that sums one tap product per cycle.
module fira_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  fira_pkg::mac_tag_t                  tag,
  input  logic signed [fira_pkg::SMP_W-1:0]   coef,
  input  logic signed [fira_pkg::SMP_W-1:0]   smp,
  output fira_pkg::mac_res_t                  res
);

  fira_pkg::mac_tag_t                 tag_a;
  fira_pkg::mac_tag_t                 tag_b;
  logic signed [fira_pkg::PROD_W-1:0] prod;
  logic signed [fira_pkg::ACC_W-1:0]  acc;
  logic signed [fira_pkg::SMP_W-1:0]  delayed;
  logic                               done;

  assign res.done    = done;
  assign res.acc     = acc;
  assign res.delayed = delayed;

  always_ff @(posedge clk) begin
    if (tag_a.prod) begin
      prod <= coef * smp;
    end else begin
      prod <= '0;
    end
    if (tag_a.vld && tag_a.last) begin
      delayed <= smp;
    end
    if (tag_b.vld) begin
      if (tag_b.first) begin
        acc <= fira_pkg::ACC_W'(prod);
      end else begin
        acc <= acc + fira_pkg::ACC_W'(prod);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_a <= '0;
      tag_b <= '0;
      done  <= 1'b0;
    end else begin
      tag_a <= tag;
      tag_b <= tag_a;
      done  <= tag_b.vld && tag_b.last;
    end
  end

endmodule

[sv/fir_filter_with_addend.sv]
// Top level of the FIR filter with addend: sequencer, registers and stream ports.
//
//  Port group  Direction  Word contents
//  s_axis      in         tuser kind; tdata sample, addend, coef_index, coef_value
//  m_axis      out        tdata filtered, delayed_sample
//  cfg         in         cfg_index selects tap_count, use_addend or emit_delayed
//
// A sample word passes through the RUN, DRAIN and WAIT states to a result in
// the output register, and the next word is accepted once the sequencer is idle
// again. With n the clamped tap count, the sequencer issues one memory read for
// each of the n taps plus one for the delayed sample through the single MAC.
// Reset clears the control registers, loads tap_count with 16 and clears the valid
// state of both memories at once. The output register lets the next word be
// accepted while a result waits for m_axis_tready; a second finished result
// holds the sequencer and keeps s_axis_tready low until the register frees up.
module fir_filter_with_addend (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [15:0] sample, [31:16] addend, [35:32] coef_index, [51:36] coef_value
  input  logic [fira_pkg::IN_DATA_W-1:0]        s_axis_tdata,
  // [0] kind
  input  logic [0:0]                            s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [22:0] filtered, [38:23] delayed_sample
  output logic [fira_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [fira_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fira_pkg::CFG_DATA_W-1:0]       cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_WAIT
  } state_t;

  state_t                              state;
  logic [fira_pkg::TAP_W-1:0]          tap_count;
  logic                                use_addend;
  logic                                emit_delayed;
  logic [fira_pkg::IDX_W-1:0]          n;
  logic [fira_pkg::IDX_W-1:0]          j;
  logic signed [fira_pkg::SMP_W-1:0]   addend;
  logic signed [fira_pkg::FILT_W-1:0]  res_filt;
  logic signed [fira_pkg::SMP_W-1:0]   res_dly;
  logic signed [fira_pkg::FILT_W-1:0]  out_filt;
  logic signed [fira_pkg::SMP_W-1:0]   out_dly;

  logic                                in_acc;
  logic                                is_load;
  logic signed [fira_pkg::SMP_W-1:0]   in_sample;
  logic signed [fira_pkg::SMP_W-1:0]   in_addend;
  logic [fira_pkg::CIDX_W-1:0]         in_cidx;
  logic signed [fira_pkg::SMP_W-1:0]   in_cval;
  logic                                coef_we;
  logic                                dly_we;
  logic                                issue;
  fira_pkg::mac_tag_t                  tag;
  fira_pkg::mac_res_t                  mac_res;
  logic signed [fira_pkg::SMP_W-1:0]   coef_rd;
  logic signed [fira_pkg::SMP_W-1:0]   dly_rd;
  logic [fira_pkg::IDX_W-1:0]          n_next;
  logic signed [fira_pkg::ACC_W-16:0]  shifted;
  logic signed [fira_pkg::SMP_W-1:0]   add_eff;
  logic signed [fira_pkg::SUM_W-1:0]   sum;
  logic signed [fira_pkg::FILT_W-1:0]  sat;
  logic                                out_free;
  logic                                out_load;

  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign cfg_ready     = !rst;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign is_load       = (fira_pkg::kind_t'(s_axis_tuser[0]) == fira_pkg::KIND_LOAD);
  assign in_sample     = s_axis_tdata[15:0];
  assign in_addend     = s_axis_tdata[31:16];
  assign in_cidx       = s_axis_tdata[35:32];
  assign in_cval       = s_axis_tdata[51:36];

  assign coef_we = in_acc && is_load && (32'(in_cidx) < 32'(fira_pkg::NTAPS));
  assign dly_we  = in_acc && !is_load;
  assign issue   = (state == ST_RUN);

  assign n_next = (32'(tap_count) > 32'(fira_pkg::NTAPS)) ?
                  fira_pkg::IDX_W'(fira_pkg::NTAPS) : fira_pkg::IDX_W'(tap_count);

  assign tag.vld   = issue;
  assign tag.first = (j == '0);
  assign tag.prod  = (j < n);
  assign tag.last  = (j == n);

  assign shifted  = mac_res.acc[fira_pkg::ACC_W-1:15];
  assign add_eff  = use_addend ? addend : '0;
  assign sum      = fira_pkg::SUM_W'(shifted) + fira_pkg::SUM_W'(add_eff);
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign out_load = (state == ST_WAIT) && out_free;

  always_comb begin
    if (sum > fira_pkg::SUM_W'(fira_pkg::FILT_MAX)) begin
      sat = fira_pkg::FILT_W'(fira_pkg::FILT_MAX);
    end else if (sum < fira_pkg::SUM_W'(fira_pkg::FILT_MIN)) begin
      sat = fira_pkg::FILT_W'(fira_pkg::FILT_MIN);
    end else begin
      sat = sum[fira_pkg::FILT_W-1:0];
    end
  end

  assign m_axis_tdata = {1'b0, out_dly, out_filt};

  fira_coef_mem u_coef (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (coef_we),
    .wr_idx  (fira_pkg::CI_W'(in_cidx)),
    .wr_data (in_cval),
    .rd_en   (issue),
    .rd_idx  (j[fira_pkg::CI_W-1:0]),
    .rd_data (coef_rd)
  );

  fira_dly_mem u_dly (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (dly_we),
    .wr_data (in_sample),
    .rd_en   (issue),
    .rd_age  (j),
    .rd_data (dly_rd)
  );

  fira_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .tag  (tag),
    .coef (coef_rd),
    .smp  (dly_rd),
    .res  (mac_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      tap_count     <= fira_pkg::TAP_W'(16);
      use_addend    <= 1'b0;
      emit_delayed  <= 1'b0;
      m_axis_tvalid <= 1'b0;
      n             <= '0;
      j             <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (fira_pkg::cfg_reg_t'(cfg_index))
          fira_pkg::REG_TAP_COUNT:    tap_count    <= cfg_data;
          fira_pkg::REG_USE_ADDEND:   use_addend   <= cfg_data[0];
          fira_pkg::REG_EMIT_DELAYED: emit_delayed <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc && !is_load) begin
            addend <= in_addend;
            n      <= n_next;
            j      <= '0;
            state  <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (j == n) begin
            state <= ST_DRAIN;
          end else begin
            j <= j + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (mac_res.done) begin
            res_filt <= sat;
            res_dly  <= emit_delayed ? mac_res.delayed : '0;
            state    <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (out_free) begin
            out_filt <= res_filt;
            out_dly  <= res_dly;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
